// ----- hdl/ffba_pkg.sv -----
// Shared constants, types and helpers of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

	localparam int HEAP_BYTES = 1024;
	localparam int HDR_BYTES  = 4;
	localparam int ADDR_W     = $clog2(HEAP_BYTES);
	localparam int LEN_W      = 16;
	// Walk positions: heap offset plus header plus a full 16-bit length.
	localparam int POS_W      = 18;
	localparam int SIZE_W     = 10;
	localparam int OFF_W      = 10;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic             free;
		logic [LEN_W-1:0] len;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	localparam hdr_t RESET_HDR = '{free: 1'b1,
		len: LEN_W'((HEAP_BYTES - HDR_BYTES) % (2 ** LEN_W))};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_A_RD,
		ST_A_CHK,
		ST_F_RD,
		ST_F_CHK,
		ST_M_RD,
		ST_M_CHK,
		ST_DONE
	} state_t;

	// True when a whole header starting at off lies inside the heap.
	function automatic logic hdr_fits(input logic [POS_W-1:0] off);
		logic [POS_W:0] endp;
		endp = {1'b0, off} + (POS_W+1)'(HDR_BYTES);
		return endp <= (POS_W+1)'(HEAP_BYTES);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/ffba_if.sv -----
// Command and result channel interfaces of the first-fit block allocator.
`default_nettype none
interface ffba_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [ffba_pkg::SIZE_W-1:0] request_size;
	logic [ffba_pkg::OFF_W-1:0]  payload_offset;

	modport source(output valid, command, request_size, payload_offset, input ready);
	modport sink(input valid, command, request_size, payload_offset, output ready);
endinterface

interface ffba_res_if;
	logic                       valid;
	logic                       ready;
	logic [ffba_pkg::OFF_W-1:0] result_offset;
	logic                       success;

	modport source(output valid, result_offset, success, input ready);
	modport sink(input valid, result_offset, success, output ready);
endinterface
`default_nettype wire

// ----- hdl/first_fit_block_allocator.sv -----
// First-fit heap allocator: header store, walk sequencer and result register.
//
// Usage: one word on cmd is either an allocate (request_size payload bytes)
// or a free (payload_offset of a block handed out earlier). Every command
// yields exactly one word on res: the payload offset of the new block, or the
// header offset of the freed block, with success; a refused request gives
// success 0 and offset 0.
// Timing: all headers sit in one RAM with a registered read port, so each
// block visited takes an address state, then a compare-and-step state. An
// allocate walks the chain from offset zero and, after a split, merges the
// remainder with a free successor. A free reads its header, then merges a
// free successor; an offset with no header in front of it goes straight to
// the result. One command is worked on at a time; cmd.ready is high only
// while the sequencer is idle.
// Reset: the heap comes up as one free block at offset zero that spans the
// whole heap; no clearing pass is needed, cmd.ready is high right after reset.
// Stall: the result sits in an output register; the next command is taken
// while it waits, but that command's result holds in the sequencer until the
// output register has been emptied.
`default_nettype none
module first_fit_block_allocator (
	input wire logic   clk,
	input wire logic   arst_n,
	ffba_cmd_if.sink   cmd,
	ffba_res_if.source res
);

	ffba_pkg::state_t state_q, state_d;

	logic [ffba_pkg::POS_W-1:0]  p_q, p_d;
	logic [ffba_pkg::SIZE_W-1:0] size_q, size_d;
	logic [ffba_pkg::ADDR_W-1:0] m_off_q, m_off_d;
	logic [ffba_pkg::LEN_W-1:0]  m_len_q, m_len_d;
	logic                        m_free_q, m_free_d;
	logic [ffba_pkg::OFF_W-1:0]  res_q, res_d;
	logic                        ok_q, ok_d;
	logic                        init0_q;
	logic                        out_valid_q;
	logic [ffba_pkg::OFF_W-1:0]  out_off_q;
	logic                        out_ok_q;

	logic                        ram_we;
	logic [ffba_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
	ffba_pkg::hdr_t              ram_wdata, ram_rdata, hdr_rd;

	logic                        accept, out_free, free_ok;
	logic [ffba_pkg::POS_W-1:0]  poff_pos, q_pos, p_adv, m_nxt, m_off_pos;
	logic [ffba_pkg::LEN_W-1:0]  rem_len, sat_len, size_len;
	logic [ffba_pkg::POS_W-1:0]  merged;
	logic                        a_fit, split_ok, rd_zero;

	ffba_ram #(
		.WIDTH(ffba_pkg::HDR_W),
		.DEPTH(ffba_pkg::HEAP_BYTES)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign accept   = cmd.valid && cmd.ready;
	assign out_free = !out_valid_q || res.ready;
	assign cmd.ready = (state_q == ffba_pkg::ST_IDLE);

	assign res.valid         = out_valid_q;
	assign res.result_offset = out_off_q;
	assign res.success       = out_ok_q;

	// Entry zero reads as the reset header until it is first written.
	assign rd_zero = init0_q &&
		((state_q == ffba_pkg::ST_A_CHK && p_q == '0) ||
		 (state_q == ffba_pkg::ST_F_CHK && m_off_q == '0));
	assign hdr_rd = rd_zero ? ffba_pkg::RESET_HDR : ram_rdata;

	assign poff_pos  = ffba_pkg::POS_W'(cmd.payload_offset);
	assign free_ok   = (poff_pos >= ffba_pkg::POS_W'(ffba_pkg::HDR_BYTES)) &&
		(poff_pos <= ffba_pkg::POS_W'(ffba_pkg::HEAP_BYTES));
	assign size_len  = ffba_pkg::LEN_W'(size_q);
	assign a_fit     = hdr_rd.free && (hdr_rd.len >= size_len);
	assign q_pos     = p_q + ffba_pkg::POS_W'(ffba_pkg::HDR_BYTES) + ffba_pkg::POS_W'(size_q);
	assign split_ok  = ((hdr_rd.len - size_len) >= ffba_pkg::LEN_W'(ffba_pkg::HDR_BYTES)) &&
		ffba_pkg::hdr_fits(q_pos);
	assign rem_len   = hdr_rd.len - size_len - ffba_pkg::LEN_W'(ffba_pkg::HDR_BYTES);
	assign p_adv     = p_q + ffba_pkg::POS_W'(ffba_pkg::HDR_BYTES) + ffba_pkg::POS_W'(hdr_rd.len);
	assign m_off_pos = ffba_pkg::POS_W'(m_off_q);
	assign m_nxt     = m_off_pos + ffba_pkg::POS_W'(ffba_pkg::HDR_BYTES) +
		ffba_pkg::POS_W'(m_len_q);
	assign merged    = ffba_pkg::POS_W'(m_len_q) + ffba_pkg::POS_W'(hdr_rd.len) +
		ffba_pkg::POS_W'(ffba_pkg::HDR_BYTES);
	assign sat_len   = (merged > ffba_pkg::POS_W'({ffba_pkg::LEN_W{1'b1}})) ?
		{ffba_pkg::LEN_W{1'b1}} : merged[ffba_pkg::LEN_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffba_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.command == ffba_pkg::CMD_ALLOC) begin
						state_d = ffba_pkg::ST_A_RD;
					end else if (free_ok) begin
						state_d = ffba_pkg::ST_F_RD;
					end else begin
						state_d = ffba_pkg::ST_DONE;
					end
				end
			end
			ffba_pkg::ST_A_RD: state_d = ffba_pkg::ST_A_CHK;
			ffba_pkg::ST_A_CHK: begin
				if (a_fit) begin
					state_d = split_ok ? ffba_pkg::ST_M_RD : ffba_pkg::ST_DONE;
				end else begin
					state_d = ffba_pkg::hdr_fits(p_adv) ? ffba_pkg::ST_A_RD : ffba_pkg::ST_DONE;
				end
			end
			ffba_pkg::ST_F_RD:  state_d = ffba_pkg::ST_F_CHK;
			ffba_pkg::ST_F_CHK: state_d = ffba_pkg::ST_M_RD;
			ffba_pkg::ST_M_RD: begin
				state_d = ffba_pkg::hdr_fits(m_nxt) ? ffba_pkg::ST_M_CHK : ffba_pkg::ST_DONE;
			end
			ffba_pkg::ST_M_CHK: state_d = ffba_pkg::ST_DONE;
			ffba_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = ffba_pkg::ST_IDLE;
				end
			end
			default: state_d = ffba_pkg::ST_IDLE;
		endcase
	end

	// datapath and RAM control
	always_comb begin
		p_d       = p_q;
		size_d    = size_q;
		m_off_d   = m_off_q;
		m_len_d   = m_len_q;
		m_free_d  = m_free_q;
		res_d     = res_q;
		ok_d      = ok_q;
		ram_we    = 1'b0;
		ram_waddr = m_off_q;
		ram_wdata = '{free: m_free_q, len: m_len_q};
		ram_raddr = p_q[ffba_pkg::ADDR_W-1:0];
		case (state_q)
			ffba_pkg::ST_IDLE: begin
				if (accept) begin
					p_d     = '0;
					size_d  = cmd.request_size;
					m_off_d = ffba_pkg::ADDR_W'(poff_pos - ffba_pkg::POS_W'(ffba_pkg::HDR_BYTES));
					res_d   = '0;
					ok_d    = 1'b0;
				end
			end
			ffba_pkg::ST_A_RD: begin
				ram_raddr = p_q[ffba_pkg::ADDR_W-1:0];
			end
			ffba_pkg::ST_A_CHK: begin
				if (a_fit) begin
					ram_we    = 1'b1;
					ram_waddr = p_q[ffba_pkg::ADDR_W-1:0];
					res_d     = ffba_pkg::OFF_W'(p_q + ffba_pkg::POS_W'(ffba_pkg::HDR_BYTES));
					ok_d      = 1'b1;
					if (split_ok) begin
						ram_wdata = '{free: 1'b0, len: size_len};
						m_off_d   = q_pos[ffba_pkg::ADDR_W-1:0];
						m_len_d   = rem_len;
						m_free_d  = 1'b1;
					end else begin
						ram_wdata = '{free: 1'b0, len: hdr_rd.len};
					end
				end else begin
					p_d = p_adv;
				end
			end
			ffba_pkg::ST_F_RD: begin
				ram_raddr = m_off_q;
			end
			ffba_pkg::ST_F_CHK: begin
				m_len_d  = hdr_rd.len;
				m_free_d = 1'b1;
				res_d    = ffba_pkg::OFF_W'(m_off_q);
				ok_d     = 1'b1;
			end
			ffba_pkg::ST_M_RD: begin
				ram_raddr = m_nxt[ffba_pkg::ADDR_W-1:0];
				// no successor inside the heap: write the header as it stands
				if (!ffba_pkg::hdr_fits(m_nxt)) begin
					ram_we = 1'b1;
				end
			end
			ffba_pkg::ST_M_CHK: begin
				ram_we = 1'b1;
				if (hdr_rd.free) begin
					ram_wdata = '{free: m_free_q, len: sat_len};
				end
			end
			ffba_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffba_pkg::ST_IDLE;
			init0_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we && ram_waddr == '0) begin
				init0_q <= 1'b0;
			end
			if (state_q == ffba_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_q      <= p_d;
		size_q   <= size_d;
		m_off_q  <= m_off_d;
		m_len_q  <= m_len_d;
		m_free_q <= m_free_d;
		res_q    <= res_d;
		ok_q     <= ok_d;
		if (state_q == ffba_pkg::ST_DONE && out_free) begin
			out_off_q <= res_q;
			out_ok_q  <= ok_q;
		end
	end

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffba_pkg::ST_IDLE) |-> !ram_we)
		else $error("header write while idle");

	a_init0_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!init0_q |=> !init0_q)
		else $error("reset header of entry zero came back");

	a_walk_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffba_pkg::ST_A_RD) |-> ffba_pkg::hdr_fits(p_q))
		else $error("walk reads a header outside the heap");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.success) |-> (res.result_offset == '0))
		else $error("refused request carries an offset");

	a_post_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffba_pkg::ST_DONE && out_free) |=> (state_q == ffba_pkg::ST_IDLE))
		else $error("result posted but sequencer not idle");

endmodule
`default_nettype wire

// ----- hdl/ffba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench of the first-fit block allocator: directed and random command traffic checked against a heap model.
`timescale 1ns / 100ps

module tb_top;
	import ffba_pkg::*;

	localparam int N_RANDOM   = 1600;
	localparam int CALM_TAIL  = 150;
	localparam int STALL_MAX  = 4000;
	localparam int DRAIN_WAIT = 600;

	typedef struct packed {
		logic              op;
		logic [SIZE_W-1:0] size;
		logic [OFF_W-1:0]  poff;
	} cmd_word_t;

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic             success;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n;

	ffba_cmd_if cmd_bus();
	ffba_res_if res_bus();

	first_fit_block_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.res(res_bus)
	);

	always #5 clk = ~clk;

	// heap model: one header per byte offset, plus which entries were ever written
	hdr_t      hdr_mem [HEAP_BYTES];
	bit        hdr_seen [HEAP_BYTES];

	cmd_word_t cmd_backlog[$];
	reply_t    due_replies[$];
	cmd_word_t next_word;
	reply_t    want;

	int n_total;
	int n_sent;
	int n_recv;
	int n_fail;
	int send_gap;
	int recv_gap;
	int idle_cycles;
	int n_alloc_ok, n_alloc_fail, n_free_ok, n_free_ign, n_split, n_merge;

	// fold the block after off into it when that block is free
	function automatic void absorb_next(int off);
		int len;
		int nxt;
		int sum;
		len = hdr_mem[off].len;
		nxt = off + HDR_BYTES + len;
		if (nxt + HDR_BYTES > HEAP_BYTES)
			return;
		if (!hdr_mem[nxt].free)
			return;
		sum = len + hdr_mem[nxt].len + HDR_BYTES;
		if (sum > 65535)
			sum = 65535;
		hdr_mem[off] = '{free: hdr_mem[off].free, len: LEN_W'(sum)};
		n_merge++;
	endfunction

	function automatic reply_t predict_reply(logic op, logic [SIZE_W-1:0] size,
		logic [OFF_W-1:0] poff);
		reply_t ans;
		int p;
		int q;
		int len;
		int sz;
		int h;
		bit found;
		ans = '{offset: '0, success: 1'b0};
		sz = int'(size);
		if (op == CMD_ALLOC) begin
			p = 0;
			found = 1'b0;
			while (!found && p + HDR_BYTES <= HEAP_BYTES) begin
				len = hdr_mem[p].len;
				if (hdr_mem[p].free && len >= sz) begin
					q = p + HDR_BYTES + sz;
					if (len - sz >= HDR_BYTES && q + HDR_BYTES <= HEAP_BYTES) begin
						hdr_mem[p] = '{free: 1'b0, len: LEN_W'(sz)};
						hdr_mem[q] = '{free: 1'b1, len: LEN_W'(len - sz - HDR_BYTES)};
						hdr_seen[q] = 1'b1;
						n_split++;
						absorb_next(q);
					end else begin
						hdr_mem[p] = '{free: 1'b0, len: LEN_W'(len)};
					end
					ans.offset  = OFF_W'(p + HDR_BYTES);
					ans.success = 1'b1;
					found = 1'b1;
				end else begin
					p = p + HDR_BYTES + len;
				end
			end
			if (found)
				n_alloc_ok++;
			else
				n_alloc_fail++;
		end else if (int'(poff) >= HDR_BYTES) begin
			h = int'(poff) - HDR_BYTES;
			hdr_mem[h] = '{free: 1'b1, len: hdr_mem[h].len};
			absorb_next(h);
			ans.offset  = OFF_W'(h);
			ans.success = 1'b1;
			n_free_ok++;
		end else begin
			n_free_ign++;
		end
		return ans;
	endfunction

	// payload offsets of allocated blocks on the current chain
	function automatic void collect_live(ref int live[$]);
		int p;
		live.delete();
		p = 0;
		while (p + HDR_BYTES <= HEAP_BYTES) begin
			if (!hdr_mem[p].free && p + HDR_BYTES < HEAP_BYTES)
				live.push_back(p + HDR_BYTES);
			p = p + HDR_BYTES + int'(hdr_mem[p].len);
		end
	endfunction

	function automatic cmd_word_t pick_word();
		cmd_word_t w;
		int live[$];
		int roll;
		int idx;
		w.op   = CMD_ALLOC;
		w.size = SIZE_W'($urandom_range(0, 1020));
		w.poff = OFF_W'($urandom_range(0, 1023));
		roll = $urandom_range(0, 99);
		collect_live(live);
		if (roll < 44 || (roll < 88 && live.size() == 0)) begin
			case ($urandom_range(0, 9))
				0:       w.size = SIZE_W'($urandom_range(0, 1020));
				1, 2:    w.size = SIZE_W'($urandom_range(0, 255));
				3:       w.size = SIZE_W'($urandom_range(1000, 1020));
				default: w.size = SIZE_W'($urandom_range(0, 32));
			endcase
		end else if (roll < 88) begin
			w.op   = CMD_FREE;
			w.poff = OFF_W'(live[$urandom_range(0, live.size() - 1)]);
		end else if (roll < 96) begin
			// any header ever written: allocated and free blocks, stale headers inside merged blocks
			w.op = CMD_FREE;
			idx = $urandom_range(0, HEAP_BYTES - 1);
			while (!hdr_seen[idx] || idx + HDR_BYTES >= HEAP_BYTES)
				idx = (idx + 1) % HEAP_BYTES;
			w.poff = OFF_W'(idx + HDR_BYTES);
		end else begin
			w.op   = CMD_FREE;
			w.poff = OFF_W'($urandom_range(0, HDR_BYTES - 1));
		end
		return w;
	endfunction

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid          <= 1'b0;
			cmd_bus.command        <= CMD_ALLOC;
			cmd_bus.request_size   <= '0;
			cmd_bus.payload_offset <= '0;
			send_gap = 0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				due_replies.push_back(predict_reply(cmd_bus.command, cmd_bus.request_size,
					cmd_bus.payload_offset));
				n_sent++;
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_bus.valid <= 1'b0;
				end else if (n_sent + CALM_TAIL < n_total && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(1, 11) - 1;
					cmd_bus.valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					next_word = cmd_backlog.pop_front();
					cmd_bus.command        <= next_word.op;
					cmd_bus.request_size   <= next_word.size;
					cmd_bus.payload_offset <= next_word.poff;
					cmd_bus.valid          <= 1'b1;
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				n_recv++;
				if (due_replies.size() == 0) begin
					if (n_fail < 10)
						$display("[%0t] unexpected result: offset %0d success %0b", $realtime,
							res_bus.result_offset, res_bus.success);
					n_fail++;
				end else begin
					want = due_replies.pop_front();
					if (res_bus.result_offset !== want.offset ||
						res_bus.success !== want.success) begin
						if (n_fail < 10)
							$display("[%0t] word %0d: offset exp %0d got %0d, success exp %0b got %0b",
								$realtime, n_recv, want.offset, res_bus.result_offset,
								want.success, res_bus.success);
						n_fail++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				res_bus.ready <= 1'b0;
			end else if (n_recv + CALM_TAIL < n_total && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(1, 11) - 1;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_MAX) begin
				$display("timeout: no handshake for %0d cycles", STALL_MAX);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		cmd_bus.valid          = 1'b0;
		cmd_bus.command        = CMD_ALLOC;
		cmd_bus.request_size   = '0;
		cmd_bus.payload_offset = '0;
		res_bus.ready          = 1'b0;
		arst_n = 1'b0;
		n_sent = 0;
		n_recv = 0;
		n_fail = 0;
		idle_cycles = 0;
		n_alloc_ok = 0; n_alloc_fail = 0; n_free_ok = 0; n_free_ign = 0;
		n_split = 0; n_merge = 0;
		for (int i = 0; i < HEAP_BYTES; i++) begin
			hdr_mem[i]  = '0;
			hdr_seen[i] = 1'b0;
		end
		hdr_mem[0]  = RESET_HDR;
		hdr_seen[0] = 1'b1;

		// directed: whole heap, refusal, frees below a header, no-room splits,
		// a zero-length tail block whose payload offset wraps, absorb on split,
		// and a free of a stale header inside a merged block
		cmd_backlog.push_back('{CMD_ALLOC, 10'd1020, 10'd1023});
		cmd_backlog.push_back('{CMD_ALLOC, 10'd0,    10'd0});
		cmd_backlog.push_back('{CMD_FREE,  10'd1020, 10'd4});
		cmd_backlog.push_back('{CMD_FREE,  10'd0,    10'd3});
		cmd_backlog.push_back('{CMD_FREE,  10'd0,    10'd0});
		cmd_backlog.push_back('{CMD_ALLOC, 10'd1018, 10'd0});
		cmd_backlog.push_back('{CMD_FREE,  10'd0,    10'd4});
		cmd_backlog.push_back('{CMD_ALLOC, 10'd1017, 10'd0});
		cmd_backlog.push_back('{CMD_FREE,  10'd0,    10'd4});
		cmd_backlog.push_back('{CMD_ALLOC, 10'd1016, 10'd0});
		cmd_backlog.push_back('{CMD_ALLOC, 10'd0,    10'd0});
		cmd_backlog.push_back('{CMD_FREE,  10'd0,    10'd4});
		cmd_backlog.push_back('{CMD_ALLOC, 10'd0,    10'd0});
		cmd_backlog.push_back('{CMD_ALLOC, 10'd100,  10'd0});
		cmd_backlog.push_back('{CMD_ALLOC, 10'd200,  10'd0});
		cmd_backlog.push_back('{CMD_FREE,  10'd0,    10'd8});
		cmd_backlog.push_back('{CMD_FREE,  10'd0,    10'd112});
		cmd_backlog.push_back('{CMD_ALLOC, 10'd50,   10'd0});
		cmd_backlog.push_back('{CMD_FREE,  10'd0,    10'd112});
		cmd_backlog.push_back('{CMD_FREE,  10'd0,    10'd8});
		cmd_backlog.push_back('{CMD_ALLOC, 10'd1020, 10'd0});
		cmd_backlog.push_back('{CMD_FREE,  10'd0,    10'd4});
		cmd_backlog.push_back('{CMD_ALLOC, 10'd511,  10'd682});
		cmd_backlog.push_back('{CMD_FREE,  10'd767,  10'd4});
		n_total = cmd_backlog.size() + N_RANDOM;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_RANDOM; i++) begin
			while (cmd_backlog.size() >= 4)
				@(posedge clk);
			cmd_backlog.push_back(pick_word());
		end

		while (n_sent < n_total || due_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d commands: %0d allocs served, %0d refused, %0d frees, %0d ignored",
			n_sent, n_alloc_ok, n_alloc_fail, n_free_ok, n_free_ign);
		$display("%0d splits, %0d merges, %0d mismatching results", n_split, n_merge, n_fail);
		if (n_fail == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/ffba_pkg.sv
hdl/ffba_if.sv
hdl/ffba_ram.sv
hdl/first_fit_block_allocator.sv
tb/sv/tb_top.sv
